### design/ffpra_pkg.sv
`default_nettype none
package ffpra_pkg;

  localparam int PAGE_COUNT = 1024;
  localparam int IDX_W      = $clog2(PAGE_COUNT);
  localparam int CNT_W      = $clog2(PAGE_COUNT + 1);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [10:0] request_count;
    logic [9:0]  page_number;
  } ffpra_in_t;

  typedef struct packed {
    logic [9:0]  run_start;
    logic        success;
    logic [31:0] allocations_made;
  } ffpra_out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACHK,
    S_SCAN,
    S_MARK,
    S_FCHK,
    S_FWR
  } ffpra_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_wr;
    logic scan;
    logic mark;
    logic free_rd;
    logic free_wr;
    logic emit_ok;
    logic emit_fail;
    logic emit_free;
  } ffpra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic want_bad;
    logic page_bad;
    logic hit;
    logic scan_miss;
    logic mark_last;
  } ffpra_stat_t;

endpackage
`default_nettype wire

### design/ffpra_ram.sv
`default_nettype none
module ffpra_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### design/ffpra_ctrl.sv
`default_nettype none
module ffpra_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               req_action,
  input  wire ffpra_pkg::ffpra_stat_t stat,
  output ffpra_pkg::ffpra_cmd_t   cmd,
  output logic                    busy
);
  import ffpra_pkg::*;

  ffpra_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = (req_action == ACT_FREE) ? S_FCHK : S_ACHK;
      end
      S_ACHK: begin
        state_nxt = stat.want_bad ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_nxt = S_MARK;
        end else if (stat.scan_miss) begin
          state_nxt = S_IDLE;
        end
      end
      S_MARK: begin
        if (stat.mark_last) state_nxt = S_IDLE;
      end
      S_FCHK: begin
        state_nxt = stat.page_bad ? S_IDLE : S_FWR;
      end
      S_FWR: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_ACHK: begin
        cmd.emit_fail = stat.want_bad;
      end
      S_SCAN: begin
        cmd.scan      = 1'b1;
        cmd.emit_fail = stat.scan_miss && !stat.hit;
      end
      S_MARK: begin
        cmd.mark    = 1'b1;
        cmd.emit_ok = stat.mark_last;
      end
      S_FCHK: begin
        cmd.emit_fail = stat.page_bad;
        cmd.free_rd   = !stat.page_bad;
      end
      S_FWR: begin
        cmd.free_wr   = 1'b1;
        cmd.emit_free = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/ffpra_dpath.sv
`default_nettype none
module ffpra_dpath (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ffpra_pkg::ffpra_in_t  in_request,
  input  wire ffpra_pkg::ffpra_cmd_t cmd,
  output ffpra_pkg::ffpra_stat_t     stat,
  output logic                       out_valid,
  output ffpra_pkg::ffpra_out_t      out_result
);
  import ffpra_pkg::*;

  ffpra_in_t         req_r;
  logic [CNT_W-1:0]  addr_r;
  logic              chk_vld_r;
  logic [IDX_W-1:0]  chk_idx_r;
  logic [CNT_W-1:0]  run_len_r;
  logic [IDX_W-1:0]  start_r;
  logic [IDX_W-1:0]  end_r;
  logic [31:0]       alloc_cnt_r;
  logic              out_valid_r;
  ffpra_out_t        out_r;

  logic              issue;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_data;
  logic              rd_data;
  logic [CNT_W-1:0]  run_inc;
  logic [CNT_W-1:0]  hit_start;

  ffpra_ram #(
    .WIDTH(1),
    .DEPTH(PAGE_COUNT)
  ) u_map (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // A read goes out each scan cycle until the address runs past the map.
  assign issue   = cmd.scan && (addr_r < CNT_W'(PAGE_COUNT));
  assign rd_en   = issue || cmd.free_rd;
  assign rd_addr = cmd.free_rd ? IDX_W'(req_r.page_number) : addr_r[IDX_W-1:0];
  assign wr_en   = cmd.clr_wr || cmd.mark || cmd.free_wr;
  assign wr_addr = cmd.free_wr ? IDX_W'(req_r.page_number) : addr_r[IDX_W-1:0];
  assign wr_data = cmd.mark;

  assign run_inc   = run_len_r + CNT_W'(1);
  assign hit_start = CNT_W'(chk_idx_r) + CNT_W'(1) - CNT_W'(req_r.request_count);

  always_comb begin
    stat.clr_last  = (addr_r == CNT_W'(PAGE_COUNT - 1));
    stat.want_bad  = (req_r.request_count == 11'd0) ||
                     (32'(req_r.request_count) > 32'(PAGE_COUNT));
    stat.page_bad  = (32'(req_r.page_number) >= 32'(PAGE_COUNT));
    stat.hit       = chk_vld_r && !rd_data &&
                     (32'(run_inc) == 32'(req_r.request_count));
    stat.scan_miss = chk_vld_r && (chk_idx_r == IDX_W'(PAGE_COUNT - 1));
    stat.mark_last = (addr_r[IDX_W-1:0] == end_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      chk_vld_r   <= 1'b0;
      run_len_r   <= '0;
      alloc_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_ok || cmd.emit_fail || cmd.emit_free;
      chk_vld_r   <= issue && !stat.hit;
      if (cmd.load) begin
        addr_r    <= '0;
        run_len_r <= '0;
      end else if (cmd.clr_wr || cmd.mark) begin
        addr_r <= addr_r + CNT_W'(1);
      end else if (cmd.scan) begin
        if (stat.hit) begin
          addr_r <= hit_start;
        end else if (issue) begin
          addr_r <= addr_r + CNT_W'(1);
        end
        if (chk_vld_r) begin
          run_len_r <= rd_data ? '0 : run_inc;
        end
      end
      if (cmd.emit_ok) begin
        alloc_cnt_r <= alloc_cnt_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_request;
    end
    if (issue) begin
      chk_idx_r <= addr_r[IDX_W-1:0];
    end
    if (cmd.scan && stat.hit) begin
      start_r <= hit_start[IDX_W-1:0];
      end_r   <= chk_idx_r;
    end
    if (cmd.emit_ok) begin
      out_r.run_start        <= 10'(start_r);
      out_r.success          <= 1'b1;
      out_r.allocations_made <= alloc_cnt_r + 32'd1;
    end else if (cmd.emit_free) begin
      out_r.run_start        <= '0;
      out_r.success          <= rd_data;
      out_r.allocations_made <= alloc_cnt_r;
    end else if (cmd.emit_fail) begin
      out_r.run_start        <= '0;
      out_r.success          <= 1'b0;
      out_r.allocations_made <= alloc_cnt_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule
`default_nettype wire

### design/first_fit_page_run_allocator.sv
`default_nettype none
// First-fit page run allocator over a 1024-page used map held in a RAM.
// A request is taken on a rising edge where start is high and busy is low;
// in_request carries the action (allocate a run or free one page), the
// wanted run length and the page to free. Every request gives exactly one
// result, shown on out_result for a single cycle with out_valid high. The
// receiver cannot stall, so a result is simply taken in that cycle.
// An allocate scans the map from page 0, one page per cycle, through the
// single RAM read port, then writes the found run one page per cycle; a bad
// length fails at the length check, before any scan. A free takes the request,
// reads the bit and clears it. The result is registered and appears in the
// cycle after the last step, and the block works on one request at a time.
// After reset the block writes zero to every map entry, with busy high, before
// it takes its first request; the allocation counter is cleared at once.
module first_fit_page_run_allocator (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire ffpra_pkg::ffpra_in_t  in_request,
  output logic                       busy,
  output logic                       out_valid,
  output ffpra_pkg::ffpra_out_t      out_result
);
  import ffpra_pkg::*;

  ffpra_cmd_t  cmd;
  ffpra_stat_t stat;

  // The controller sequences clear, scan, mark and free steps.
  ffpra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_action(in_request.action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // The datapath holds the map RAM, the scan counters and the result register.
  ffpra_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_request(in_request),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_result(out_result)
  );

endmodule
`default_nettype wire
